/* rtl/core/bcomp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcomp_pkg: shared types and constants
// Opcodes of the shared arithmetic unit, sequencer states and widths.
// ----------------------------------------------------------------------------
package bcomp_pkg;

    localparam int unsigned ADC_W  = 20;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned CFG_W  = 64;
    localparam int unsigned IDX_W  = 2;
    localparam int unsigned OUT_W  = 32;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CAL_TEMP  = 2'd0;
    localparam logic [IDX_W-1:0] REG_PRESS_LOW = 2'd1;
    localparam logic [IDX_W-1:0] REG_PRESS_HI  = 2'd2;
    localparam logic [IDX_W-1:0] REG_PRESS_LST = 2'd3;

    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    // ALU opcodes
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_SHL,
        OP_SRA
    } alu_op_t;

    // 64-bit two's complement wrap multiply is done bit-serially
    localparam int unsigned MUL_STEPS = 64;
    localparam int unsigned DIV_STEPS = 64;

endpackage
`default_nettype wire

/* rtl/core/barometric_compensation.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barometric_compensation: temperature and pressure compensation
// Integer compensation formulas run as a microprogram over one ALU and a
// shared bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | s_cmd, s_raw_adc
// m_      | out       | m_valid / m_ready  | m_result_kind, m_temperature_centi,
//         |           |                    | m_pressure_q24_8, m_divide_fault
// cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// Each multiply or divide micro-op waits in ST_MUL or ST_DIV until the shared
// unit signals done; every other micro-op executes in ST_RUN. A pressure
// request whose divisor is zero ends early with m_divide_fault set.
// One request at a time: s_ready is high only in idle. The result is held in
// an output register until taken; then the block leaves ST_OUT for idle.
// Reset clears calibration and fine temp.
// ----------------------------------------------------------------------------
module barometric_compensation (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [19:0]                   s_raw_adc,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_result_kind,
    output logic signed [31:0]                 m_temperature_centi,
    output logic [31:0]                        m_pressure_q24_8,
    output logic                               m_divide_fault,
    input  wire logic                          cfg_we,
    input  wire logic [bcomp_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [bcomp_pkg::CFG_W-1:0]   cfg_data
);

    localparam int unsigned W = bcomp_pkg::WORD_W;

    // micro-op kinds
    localparam logic [2:0] K_ALU  = 3'd0;
    localparam logic [2:0] K_MUL  = 3'd1;
    localparam logic [2:0] K_DIV  = 3'd2;
    localparam logic [2:0] K_END  = 3'd3;
    localparam logic [2:0] K_ZCHK = 3'd4;

    // register file slots (small, fixed selection)
    localparam logic [3:0] R_ADC = 4'd0, R_T1 = 4'd1, R_T2 = 4'd2, R_T3 = 4'd3;
    localparam logic [3:0] R_P1 = 4'd4, R_P2 = 4'd5, R_P3 = 4'd6, R_P4 = 4'd7;
    localparam logic [3:0] R_P5 = 4'd8, R_P6 = 4'd9, R_P7 = 4'd10, R_P8 = 4'd11;
    localparam logic [3:0] R_P9 = 4'd12, R_X = 4'd13, R_Y = 4'd14, R_Z = 4'd15;
    // extra temporaries
    localparam logic [4:0] R_C  = 5'd16;  // constant operand
    localparam logic [4:0] R_TF = 5'd17;
    localparam logic [4:0] R_V  = 5'd18;
    localparam logic [4:0] R_U  = 5'd19;

    typedef struct packed {
        logic [2:0]          kind;
        bcomp_pkg::alu_op_t  op;
        logic [4:0]          a;
        logic [4:0]          b;
        logic [4:0]          d;
        logic [5:0]          sh;   // shift amount for SHL/SRA
        logic [W-1:0]        c;    // constant read as operand R_C
    } uop_t;

    function automatic uop_t mk(input logic [2:0] k, input bcomp_pkg::alu_op_t o,
                                input logic [4:0] a, input logic [4:0] b,
                                input logic [4:0] d, input logic [5:0] sh,
                                input logic [W-1:0] c);
        uop_t u;
        u.kind = k; u.op = o; u.a = a; u.b = b; u.d = d; u.sh = sh; u.c = c;
        return u;
    endfunction

    localparam logic [4:0] X = {1'b0, R_X}, Y = {1'b0, R_Y}, Z = {1'b0, R_Z};
    localparam logic [4:0] A = {1'b0, R_ADC};

    // microprogram: temperature at 0, pressure at 32
    function automatic uop_t prog(input logic [5:0] pc);
        uop_t u;
        u = mk(K_END, bcomp_pkg::OP_ADD, '0, '0, '0, '0, '0);
        case (pc)
            // d1 = (adc>>3) - (t1<<1)
            6'd0:  u = mk(K_ALU, bcomp_pkg::OP_SRA, A, A, X, 6'd3, '0);
            6'd1:  u = mk(K_ALU, bcomp_pkg::OP_SHL, 5'(R_T1), A, Y, 6'd1, '0);
            6'd2:  u = mk(K_ALU, bcomp_pkg::OP_SUB, X, Y, X, 6'd0, '0);
            6'd3:  u = mk(K_MUL, bcomp_pkg::OP_ADD, X, 5'(R_T2), X, 6'd0, '0);
            6'd4:  u = mk(K_ALU, bcomp_pkg::OP_SRA, X, X, X, 6'd11, '0);
            // d2 = (adc>>4) - t1
            6'd5:  u = mk(K_ALU, bcomp_pkg::OP_SRA, A, A, Y, 6'd4, '0);
            6'd6:  u = mk(K_ALU, bcomp_pkg::OP_SUB, Y, 5'(R_T1), Y, 6'd0, '0);
            6'd7:  u = mk(K_MUL, bcomp_pkg::OP_ADD, Y, Y, Y, 6'd0, '0);
            6'd8:  u = mk(K_ALU, bcomp_pkg::OP_SRA, Y, Y, Y, 6'd12, '0);
            6'd9:  u = mk(K_MUL, bcomp_pkg::OP_ADD, Y, 5'(R_T3), Y, 6'd0, '0);
            6'd10: u = mk(K_ALU, bcomp_pkg::OP_SRA, Y, Y, Y, 6'd14, '0);
            6'd11: u = mk(K_ALU, bcomp_pkg::OP_ADD, X, Y, R_TF, 6'd0, '0);
            // t = (tf*5 + 128) >> 8
            6'd12: u = mk(K_ALU, bcomp_pkg::OP_SHL, R_TF, A, X, 6'd2, '0);
            6'd13: u = mk(K_ALU, bcomp_pkg::OP_ADD, X, R_TF, X, 6'd0, '0);
            6'd14: u = mk(K_ALU, bcomp_pkg::OP_ADD, X, R_C, X, 6'd0, 64'd128);
            6'd15: u = mk(K_ALU, bcomp_pkg::OP_SRA, X, X, X, 6'd8, '0);
            6'd16: u = mk(K_END, bcomp_pkg::OP_ADD, '0, '0, '0, '0, '0);
            // pressure: v1 = tf - 128000 -> Z
            6'd32: u = mk(K_ALU, bcomp_pkg::OP_SUB, R_TF, R_C, Z, 6'd0, 64'd128000);
            6'd33: u = mk(K_MUL, bcomp_pkg::OP_ADD, Z, Z, R_U, 6'd0, '0);   // U=v1*v1
            6'd34: u = mk(K_MUL, bcomp_pkg::OP_ADD, R_U, 5'(R_P6), Y, 6'd0, '0);
            6'd35: u = mk(K_MUL, bcomp_pkg::OP_ADD, Z, 5'(R_P5), X, 6'd0, '0);
            6'd36: u = mk(K_ALU, bcomp_pkg::OP_SHL, X, X, X, 6'd17, '0);
            6'd37: u = mk(K_ALU, bcomp_pkg::OP_ADD, Y, X, Y, 6'd0, '0);
            6'd38: u = mk(K_ALU, bcomp_pkg::OP_SHL, 5'(R_P4), X, X, 6'd35, '0);
            6'd39: u = mk(K_ALU, bcomp_pkg::OP_ADD, Y, X, Y, 6'd0, '0);       // Y=v2
            6'd40: u = mk(K_MUL, bcomp_pkg::OP_ADD, R_U, 5'(R_P3), X, 6'd0, '0);
            6'd41: u = mk(K_ALU, bcomp_pkg::OP_SRA, X, X, X, 6'd8, '0);
            6'd42: u = mk(K_MUL, bcomp_pkg::OP_ADD, Z, 5'(R_P2), R_V, 6'd0, '0);
            6'd43: u = mk(K_ALU, bcomp_pkg::OP_SHL, R_V, X, R_V, 6'd12, '0);
            6'd44: u = mk(K_ALU, bcomp_pkg::OP_ADD, X, R_V, X, 6'd0, '0);
            6'd45: u = mk(K_ALU, bcomp_pkg::OP_ADD, X, R_C, X, 6'd0, 64'h0000_8000_0000_0000);
            6'd46: u = mk(K_MUL, bcomp_pkg::OP_ADD, X, 5'(R_P1), X, 6'd0, '0);
            6'd47: u = mk(K_ALU, bcomp_pkg::OP_SRA, X, X, Z, 6'd33, '0);      // Z=v1
            6'd48: u = mk(K_ZCHK, bcomp_pkg::OP_ADD, Z, Z, Z, 6'd0, '0);
            // p = 1048576 - adc; ((p<<31) - v2) * 3125
            6'd49: u = mk(K_ALU, bcomp_pkg::OP_SUB, R_C, A, X, 6'd0, 64'd1048576);
            6'd50: u = mk(K_ALU, bcomp_pkg::OP_SHL, X, X, X, 6'd31, '0);
            6'd51: u = mk(K_ALU, bcomp_pkg::OP_SUB, X, Y, X, 6'd0, '0);
            6'd52: u = mk(K_MUL, bcomp_pkg::OP_ADD, X, R_C, X, 6'd0, 64'd3125);
            6'd53: u = mk(K_DIV, bcomp_pkg::OP_ADD, X, Z, X, 6'd0, '0);       // X=p
            6'd54: u = mk(K_ALU, bcomp_pkg::OP_SRA, X, X, Y, 6'd13, '0);      // Y=ps
            6'd55: u = mk(K_MUL, bcomp_pkg::OP_ADD, Y, Y, Y, 6'd0, '0);
            6'd56: u = mk(K_MUL, bcomp_pkg::OP_ADD, Y, 5'(R_P9), Y, 6'd0, '0);
            6'd57: u = mk(K_ALU, bcomp_pkg::OP_SRA, Y, Y, Y, 6'd25, '0);
            6'd58: u = mk(K_MUL, bcomp_pkg::OP_ADD, X, 5'(R_P8), Z, 6'd0, '0);
            6'd59: u = mk(K_ALU, bcomp_pkg::OP_SRA, Z, Z, Z, 6'd19, '0);
            6'd60: u = mk(K_ALU, bcomp_pkg::OP_ADD, X, Y, X, 6'd0, '0);
            6'd61: u = mk(K_ALU, bcomp_pkg::OP_ADD, X, Z, X, 6'd0, '0);
            6'd62: u = mk(K_ALU, bcomp_pkg::OP_SRA, X, X, X, 6'd8, '0);
            6'd63: u = mk(K_ALU, bcomp_pkg::OP_SHL, 5'(R_P7), X, Y, 6'd4, '0);
            default: u = mk(K_END, bcomp_pkg::OP_ADD, '0, '0, '0, '0, '0);
        endcase
        return u;
    endfunction

    // calibration registers
    logic [47:0]  cal_temp_reg;
    logic [63:0]  cal_plo_reg;
    logic [63:0]  cal_phi_reg;
    logic [15:0]  cal_plast_reg;
    logic [31:0]  fine_t_reg;

    bcomp_pkg::state_t state_reg, state_next;
    logic [5:0]   pc_reg, pc_next;
    logic         kind_reg;
    logic [19:0]  adc_reg;
    logic [W-1:0] x_reg, y_reg, z_reg, u_reg, v_reg, tf_reg;
    logic         m_valid_reg;
    logic         m_kind_reg, m_fault_reg;
    logic [31:0]  m_temp_reg, m_press_reg;
    logic         neg_reg;

    uop_t         uop;
    logic [W-1:0] opa, opb, alu_res;
    logic         mul_start, div_start, md_done;
    logic [W-1:0] md_a, md_b, md_res;
    logic         final_step;

    function automatic logic [W-1:0] sx(input logic [15:0] w);
        return {{(W-16){w[15]}}, w};
    endfunction

    function automatic logic [W-1:0] rd(input logic [4:0] s, input logic [W-1:0] c);
        logic [W-1:0] r;
        r = '0;
        case (s)
            5'd0:  r = {44'd0, adc_reg};
            5'd1:  r = {48'd0, cal_temp_reg[15:0]};
            5'd2:  r = sx(cal_temp_reg[31:16]);
            5'd3:  r = sx(cal_temp_reg[47:32]);
            5'd4:  r = {48'd0, cal_plo_reg[15:0]};
            5'd5:  r = sx(cal_plo_reg[31:16]);
            5'd6:  r = sx(cal_plo_reg[47:32]);
            5'd7:  r = sx(cal_plo_reg[63:48]);
            5'd8:  r = sx(cal_phi_reg[15:0]);
            5'd9:  r = sx(cal_phi_reg[31:16]);
            5'd10: r = sx(cal_phi_reg[47:32]);
            5'd11: r = sx(cal_phi_reg[63:48]);
            5'd12: r = sx(cal_plast_reg);
            5'd13: r = x_reg;
            5'd14: r = y_reg;
            5'd15: r = z_reg;
            5'd16: r = c;
            5'd17: r = tf_reg;
            5'd18: r = v_reg;
            5'd19: r = u_reg;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign uop = prog(pc_reg);

    // operand fetch
    always_comb begin
        opa = rd(uop.a, uop.c);
        opb = rd(uop.b, uop.c);
    end

    // shared ALU
    always_comb begin
        case (uop.op)
            bcomp_pkg::OP_ADD: alu_res = opa + opb;
            bcomp_pkg::OP_SUB: alu_res = opa - opb;
            bcomp_pkg::OP_SHL: alu_res = opa << uop.sh;
            bcomp_pkg::OP_SRA: alu_res = W'($signed(opa) >>> uop.sh);
            default:           alu_res = opa;
        endcase
    end

    // divider works on magnitudes
    always_comb begin
        md_a = opa;
        md_b = opb;
        if (uop.kind == K_DIV) begin
            md_a = opa[W-1] ? -opa : opa;
            md_b = opb[W-1] ? -opb : opb;
        end
    end

    assign mul_start = (state_reg == bcomp_pkg::ST_RUN) && (uop.kind == K_MUL);
    assign div_start = (state_reg == bcomp_pkg::ST_RUN) && (uop.kind == K_DIV);

    bcomp_muldiv u_muldiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_mul (mul_start),
        .start_div (div_start),
        .op_a      (md_a),
        .op_b      (md_b),
        .done      (md_done),
        .result    (md_res)
    );

    assign final_step = (uop.kind == K_END) || (pc_reg == 6'd63);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bcomp_pkg::ST_IDLE: if (s_valid) state_next = bcomp_pkg::ST_RUN;
            bcomp_pkg::ST_RUN: begin
                if (uop.kind == K_MUL) begin
                    state_next = bcomp_pkg::ST_MUL;
                end else if (uop.kind == K_DIV) begin
                    state_next = bcomp_pkg::ST_DIV;
                end else if (uop.kind == K_ZCHK && z_reg == '0) begin
                    state_next = bcomp_pkg::ST_OUT;
                end else if (final_step) begin
                    state_next = bcomp_pkg::ST_OUT;
                end
            end
            bcomp_pkg::ST_MUL, bcomp_pkg::ST_DIV:
                if (md_done) state_next = bcomp_pkg::ST_RUN;
            bcomp_pkg::ST_OUT: if (!m_valid_reg) state_next = bcomp_pkg::ST_IDLE;
            default: state_next = bcomp_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = (state_reg == bcomp_pkg::ST_IDLE);
        pc_next = pc_reg;
        unique case (state_reg)
            bcomp_pkg::ST_IDLE: pc_next = s_cmd ? 6'd32 : 6'd0;
            bcomp_pkg::ST_RUN:
                if (uop.kind != K_MUL && uop.kind != K_DIV) pc_next = pc_reg + 6'd1;
            bcomp_pkg::ST_MUL, bcomp_pkg::ST_DIV:
                if (md_done) pc_next = pc_reg + 6'd1;
            default: pc_next = pc_reg;
        endcase
    end

    // datapath writeback
    always_ff @(posedge aclk) begin
        if (state_reg == bcomp_pkg::ST_IDLE && s_valid) begin
            kind_reg <= s_cmd;
            adc_reg  <= s_raw_adc;
            tf_reg   <= {{32{fine_t_reg[31]}}, fine_t_reg};
        end
        if (div_start) begin
            neg_reg <= opa[W-1] ^ opb[W-1];
        end
        if ((state_reg == bcomp_pkg::ST_RUN && uop.kind == K_ALU) ||
            ((state_reg == bcomp_pkg::ST_MUL || state_reg == bcomp_pkg::ST_DIV)
             && md_done)) begin
            logic [W-1:0] v;
            v = alu_res;
            if (state_reg == bcomp_pkg::ST_MUL) v = md_res;
            if (state_reg == bcomp_pkg::ST_DIV) v = neg_reg ? -md_res : md_res;
            case (uop.d)
                5'd13: x_reg  <= v;
                5'd14: y_reg  <= v;
                5'd15: z_reg  <= v;
                5'd17: tf_reg <= v;
                5'd18: v_reg  <= v;
                5'd19: u_reg  <= v;
                default: x_reg <= x_reg;
            endcase
        end
    end

    // control, calibration and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bcomp_pkg::ST_IDLE;
            pc_reg        <= '0;
            m_valid_reg   <= 1'b0;
            cal_temp_reg  <= '0;
            cal_plo_reg   <= '0;
            cal_phi_reg   <= '0;
            cal_plast_reg <= '0;
            fine_t_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    bcomp_pkg::REG_CAL_TEMP:  cal_temp_reg  <= cfg_data[47:0];
                    bcomp_pkg::REG_PRESS_LOW: cal_plo_reg   <= cfg_data;
                    bcomp_pkg::REG_PRESS_HI:  cal_phi_reg   <= cfg_data;
                    bcomp_pkg::REG_PRESS_LST: cal_plast_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // finish: load result register
            if (state_reg == bcomp_pkg::ST_RUN && !m_valid_reg &&
                (final_step || (uop.kind == K_ZCHK && z_reg == '0))) begin
                m_valid_reg <= 1'b1;
                m_kind_reg  <= kind_reg;
                if (kind_reg == bcomp_pkg::CMD_TEMP) begin
                    fine_t_reg  <= tf_reg[31:0];
                    m_temp_reg  <= x_reg[31:0];
                    m_press_reg <= '0;
                    m_fault_reg <= 1'b0;
                end else if (uop.kind == K_ZCHK) begin
                    m_temp_reg  <= '0;
                    m_press_reg <= '0;
                    m_fault_reg <= 1'b1;
                end else begin
                    m_temp_reg  <= '0;
                    m_press_reg <= x_reg[31:0] + alu_res[31:0];
                    m_fault_reg <= 1'b0;
                end
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_result_kind       = m_kind_reg;
    assign m_temperature_centi = m_temp_reg;
    assign m_pressure_q24_8    = m_press_reg;
    assign m_divide_fault      = m_fault_reg;

endmodule
`default_nettype wire

/* rtl/core/bcomp_muldiv.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcomp_muldiv: shared iterative multiplier and divider
// Radix-2 wrap multiply (low 64 bits) and restoring unsigned divide, one
// bit per cycle. Signs of the divide are handled by the caller.
// ----------------------------------------------------------------------------
module bcomp_muldiv (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start_mul,
    input  wire logic                          start_div,
    input  wire logic [bcomp_pkg::WORD_W-1:0]  op_a,
    input  wire logic [bcomp_pkg::WORD_W-1:0]  op_b,
    output logic                               done,
    output logic [bcomp_pkg::WORD_W-1:0]       result
);

    localparam int unsigned W = bcomp_pkg::WORD_W;

    logic          busy_reg, busy_next;
    logic          is_div_reg, is_div_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W:0]    trial;
    logic [W-1:0]  rem_sh;

    assign rem_sh = {acc_reg[W-2:0], a_reg[W-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, b_reg};

    // one multiply or divide step per cycle
    always_comb begin
        busy_next   = busy_reg;
        is_div_next = is_div_reg;
        cnt_next    = cnt_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        done        = 1'b0;
        if (!busy_reg) begin
            if (start_mul || start_div) begin
                busy_next   = 1'b1;
                is_div_next = start_div;
                cnt_next    = '0;
                a_next      = op_a;
                b_next      = op_b;
                acc_next    = '0;
            end
        end else if (!is_div_reg) begin
            if (a_reg[0]) begin
                acc_next = acc_reg + b_reg;
            end
            a_next   = a_reg >> 1;
            b_next   = b_reg << 1;
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(bcomp_pkg::MUL_STEPS - 1)) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end else begin
            // remainder in acc, quotient shifts into a
            if (!trial[W] || acc_reg[W-1]) begin
                acc_next = trial[W-1:0];
                a_next   = {a_reg[W-2:0], 1'b1};
            end else begin
                acc_next = rem_sh;
                a_next   = {a_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(bcomp_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_comb begin
        result = is_div_reg ? a_next : acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        is_div_reg <= is_div_next;
        cnt_reg    <= cnt_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
    end

endmodule
`default_nettype wire
